@@ rtl/core/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Clocked on clock, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/sphrc_pkg.sv @@
// -----------------------------------------------------------------------------
// sphrc_pkg
// Types, codes and helper functions of the solenoid peak/hold controller.
// -----------------------------------------------------------------------------
package sphrc_pkg;

   // Command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_SENSOR = 2'd2;

   // Event codes
   localparam logic [1:0] EVT_NONE     = 2'd0;
   localparam logic [1:0] EVT_TIMEOUT  = 2'd1;
   localparam logic [1:0] EVT_RELEASED = 2'd2;
   localparam logic [1:0] EVT_RETURNED = 2'd3;

   // Register indexes (paddr bit 2)
   localparam logic REG_PULSE_COUNT = 1'b0;
   localparam logic REG_SPIN_WINDOW = 1'b1;

   // Reset values of the registers
   localparam logic [2:0] PULSE_COUNT_RST = 3'd3;
   localparam logic [7:0] SPIN_WINDOW_RST = 8'd10;

   localparam logic [7:0]  DUTY_OFF     = 8'd0;
   localparam logic [7:0]  TIMEOUT_OFF  = 8'd0;
   localparam logic [7:0]  TIMEOUT_NONE = 8'hFF;
   localparam logic [3:0]  PHASE_RST    = 4'd15;
   localparam logic [3:0]  PHASE_START  = 4'd1;
   localparam logic [6:0]  PCT_MAX      = 7'd100;
   // 255/100 scaled by 2^22 and biased upward, exact for every percentage up to 100
   localparam logic [30:0] DUTY_RECIP   = 31'd10695721;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] inrush_pct;
      logic [7:0] inrush_period;
      logic [6:0] hold_pct;
      logic [7:0] timeout_sec;
      logic       sensor_a;
      logic       sensor_b;
   } sphrc_req_type;

   typedef struct packed {
      logic [7:0] duty;
      logic       active;
      logic [1:0] event_res;
      logic       id_read_request;
   } sphrc_rsp_type;

   typedef struct packed {
      logic [2:0] inrush_pulse_count;
      logic [7:0] spin_window;
   } sphrc_cfg_type;

   // Percentage to 8-bit duty: min(pct,100)*255/100
   function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
      logic [6:0]  p;
      logic [30:0] prod;
      p    = (pct > PCT_MAX) ? PCT_MAX : pct;
      prod = 31'(p) * DUTY_RECIP;
      return prod[29:22];
   endfunction

endpackage

@@ rtl/core/sphrc_core.sv @@
// -----------------------------------------------------------------------------
// sphrc_core
// Controller state and its combinational next-state update for one transaction.
// -----------------------------------------------------------------------------
module sphrc_core import sphrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  sphrc_req_type item,
   input  sphrc_cfg_type cfg,
   output sphrc_rsp_type result
);

   logic        solenoid_on_ff,    solenoid_on_in;
   logic        timeout_armed_ff,  timeout_armed_in;
   logic [3:0]  pulse_phase_ff,    pulse_phase_in;
   logic [7:0]  inrush_duty_ff,    inrush_duty_in;
   logic [7:0]  hold_duty_ff,      hold_duty_in;
   logic [7:0]  pulse_length_ff,   pulse_length_in;
   logic [7:0]  pulse_timer_ff,    pulse_timer_in;
   logic [11:0] run_timer_ff,      run_timer_in;
   logic [7:0]  spin_timer_ff,     spin_timer_in;
   logic        return_started_ff, return_started_in;
   logic        remove_started_ff, remove_started_in;
   logic [7:0]  duty_reg_ff,       duty_reg_in;

   logic [7:0]  pulse_dec;
   logic [11:0] run_dec;
   logic [7:0]  spin_dec;
   logic [11:0] tmo_ticks;
   logic [10:0] period_x_count;
   logic [11:0] pulse_ticks;
   logic        ret_live;
   logic        rem_live;
   logic [1:0]  event_code;
   logic        id_req;

   // Timer countdowns and run-time candidates
   assign pulse_dec      = pulse_timer_ff - 8'(pulse_timer_ff != 8'd0);
   assign run_dec        = run_timer_ff - 12'(run_timer_ff != 12'd0);
   assign spin_dec       = spin_timer_ff - 8'(spin_timer_ff != 8'd0);
   assign tmo_ticks      = {1'b0, item.timeout_sec, 3'b000} + {3'b000, item.timeout_sec, 1'b0};
   assign period_x_count = 11'(item.inrush_period) * 11'(cfg.inrush_pulse_count);
   assign pulse_ticks    = {period_x_count, 1'b0};
   assign ret_live       = return_started_ff && (spin_timer_ff != 8'd0);
   assign rem_live       = remove_started_ff && (spin_timer_ff != 8'd0);

   // Next state per command
   always_comb begin
      solenoid_on_in    = solenoid_on_ff;
      timeout_armed_in  = timeout_armed_ff;
      pulse_phase_in    = pulse_phase_ff;
      inrush_duty_in    = inrush_duty_ff;
      hold_duty_in      = hold_duty_ff;
      pulse_length_in   = pulse_length_ff;
      pulse_timer_in    = pulse_timer_ff;
      run_timer_in      = run_timer_ff;
      spin_timer_in     = spin_timer_ff;
      return_started_in = return_started_ff;
      remove_started_in = remove_started_ff;
      duty_reg_in       = duty_reg_ff;
      event_code        = EVT_NONE;
      id_req            = 1'b0;
      unique case (item.command)
         CMD_TICK: begin
            pulse_timer_in = pulse_dec;
            run_timer_in   = run_dec;
            spin_timer_in  = spin_dec;
            if (solenoid_on_ff && (run_dec == 12'd0) && timeout_armed_ff) begin
               // run time over: switch off and report
               pulse_timer_in   = 8'd0;
               run_timer_in     = 12'd0;
               duty_reg_in      = DUTY_OFF;
               solenoid_on_in   = 1'b0;
               timeout_armed_in = 1'b1;
               event_code       = EVT_TIMEOUT;
            end else if (solenoid_on_ff) begin
               if (pulse_dec == 8'd0) begin
                  if (pulse_phase_ff < {cfg.inrush_pulse_count, 1'b0}) begin
                     duty_reg_in    = pulse_phase_ff[0] ? hold_duty_ff : inrush_duty_ff;
                     pulse_phase_in = pulse_phase_ff + 4'd1;
                     pulse_timer_in = pulse_length_ff;
                  end else begin
                     duty_reg_in = hold_duty_ff;
                  end
               end
            end else begin
               pulse_timer_in   = 8'd0;
               run_timer_in     = 12'd0;
               duty_reg_in      = DUTY_OFF;
               timeout_armed_in = 1'b1;
            end
         end
         CMD_START: begin
            if (item.timeout_sec != TIMEOUT_OFF) begin
               pulse_length_in  = item.inrush_period;
               pulse_timer_in   = item.inrush_period;
               inrush_duty_in   = pct_to_duty(item.inrush_pct);
               duty_reg_in      = pct_to_duty(item.inrush_pct);
               hold_duty_in     = pct_to_duty(item.hold_pct);
               pulse_phase_in   = PHASE_START;
               solenoid_on_in   = 1'b1;
               run_timer_in     = (tmo_ticks > pulse_ticks) ? tmo_ticks : pulse_ticks;
               timeout_armed_in = (item.timeout_sec != TIMEOUT_NONE);
            end else begin
               pulse_timer_in   = 8'd0;
               run_timer_in     = 12'd0;
               duty_reg_in      = DUTY_OFF;
               solenoid_on_in   = 1'b0;
               timeout_armed_in = 1'b1;
            end
         end
         CMD_SENSOR: begin
            // begun flags lapse once the spin window has run out
            return_started_in = ret_live;
            remove_started_in = rem_live;
            if (ret_live) begin
               if (item.sensor_a) begin
                  event_code    = EVT_RETURNED;
                  spin_timer_in = 8'd0;
               end
            end else if (rem_live) begin
               if (item.sensor_a && item.sensor_b) begin
                  id_req           = 1'b1;
                  event_code       = EVT_RELEASED;
                  spin_timer_in    = 8'd0;
                  pulse_timer_in   = 8'd0;
                  run_timer_in     = 12'd0;
                  duty_reg_in      = DUTY_OFF;
                  solenoid_on_in   = 1'b0;
                  timeout_armed_in = 1'b1;
               end
            end else if (!item.sensor_a) begin
               spin_timer_in = cfg.spin_window;
               if (!item.sensor_b) begin
                  remove_started_in = 1'b1;
               end else begin
                  id_req            = 1'b1;
                  return_started_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         solenoid_on_ff    <= 1'b0;
         timeout_armed_ff  <= 1'b1;
         pulse_phase_ff    <= PHASE_RST;
         inrush_duty_ff    <= DUTY_OFF;
         hold_duty_ff      <= DUTY_OFF;
         pulse_length_ff   <= 8'd0;
         pulse_timer_ff    <= 8'd0;
         run_timer_ff      <= 12'd0;
         spin_timer_ff     <= 8'd0;
         return_started_ff <= 1'b0;
         remove_started_ff <= 1'b0;
         duty_reg_ff       <= DUTY_OFF;
      end else if (fire) begin
         solenoid_on_ff    <= solenoid_on_in;
         timeout_armed_ff  <= timeout_armed_in;
         pulse_phase_ff    <= pulse_phase_in;
         inrush_duty_ff    <= inrush_duty_in;
         hold_duty_ff      <= hold_duty_in;
         pulse_length_ff   <= pulse_length_in;
         pulse_timer_ff    <= pulse_timer_in;
         run_timer_ff      <= run_timer_in;
         spin_timer_ff     <= spin_timer_in;
         return_started_ff <= return_started_in;
         remove_started_ff <= remove_started_in;
         duty_reg_ff       <= duty_reg_in;
      end
   end

   // Result of this transaction
   assign result.duty            = duty_reg_in;
   assign result.active          = solenoid_on_in;
   assign result.event_res       = event_code;
   assign result.id_read_request = id_req;

endmodule

@@ rtl/core/solenoid_peak_hold_release_controller.sv @@
// -----------------------------------------------------------------------------
// solenoid_peak_hold_release_controller
// Peak-and-hold solenoid drive with timeouts and a two-sensor wheel detector.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transaction: a 100 ms tick, a start/stop
//   with duty and timing settings, or a sensor edge with both sensor levels.
//   rsp_* returns exactly one result per command: duty, active, event code
//   and an ID-read request flag.
//   csr_* is an APB-style port: pulse count at 0x0, spin window at 0x4.
//   Write it only while no command is in flight.
// Path: an accepted command passes the input register, then the result register,
//   on its way to rsp_*; it waits in the input register while rsp_* is stalled.
// Throughput: one command per cycle unless rsp_* stalls; the whole update is
//   one pass through the state logic in sphrc_core.
// Reset: solenoid off, timers stopped, pulse count 3, spin window 10, no
//   transactions held.
// Stall: while rsp_ready is low the result holds; one more command waits in
//   the input register, after which req_ready drops.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module solenoid_peak_hold_release_controller import sphrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // command channel
   input  logic          req_valid,
   output logic          req_ready,
   input  sphrc_req_type req_data,
   // result channel
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output sphrc_rsp_type rsp_data,
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   logic          in_valid_ff, in_valid_in;
   sphrc_req_type in_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   sphrc_rsp_type rsp_data_ff;
   sphrc_rsp_type core_result;
   sphrc_cfg_type cfg_ff;
   logic          advance;
   logic          csr_write;

   // Pipeline control
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   sphrc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inrush_pulse_count <= PULSE_COUNT_RST;
         cfg_ff.spin_window        <= SPIN_WINDOW_RST;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_PULSE_COUNT: cfg_ff.inrush_pulse_count <= csr_pwdata[2:0];
            REG_SPIN_WINDOW: cfg_ff.spin_window        <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PULSE_COUNT: csr_prdata = {29'd0, cfg_ff.inrush_pulse_count};
         REG_SPIN_WINDOW: csr_prdata = {24'd0, cfg_ff.spin_window};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Checks
   `ASSERT_IMPL(a_off_zero_duty, rsp_valid_ff && !rsp_data_ff.active, rsp_data_ff.duty == DUTY_OFF)
   `ASSERT_IMPL(a_timeout_off, rsp_valid_ff && (rsp_data_ff.event_res == EVT_TIMEOUT), !rsp_data_ff.active && !rsp_data_ff.id_read_request)
   `ASSERT_IMPL(a_release_off, rsp_valid_ff && (rsp_data_ff.event_res == EVT_RELEASED), !rsp_data_ff.active && rsp_data_ff.id_read_request)
   `ASSERT_NEXT(a_input_held, in_valid_ff && !advance, in_valid_ff)

endmodule

@@ verif/tb_solenoid_peak_hold_release_controller.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_solenoid_peak_hold_release_controller
// Self-checking bench for the peak/hold solenoid controller. A directed burst
// covers duty saturation, stop, disabled timeout and both wheel spins; random
// drive runs, spin sequences and noise follow under several register settings
// and back-pressure modes. Every status result is checked against a built-in
// model of the drive, timers and wheel detector.
// -----------------------------------------------------------------------------
module tb_solenoid_peak_hold_release_controller;
   import sphrc_pkg::*;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         RANDOM_ITEMS   = 1950;
   localparam int         SEGMENTS       = 8;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   sphrc_req_type req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   sphrc_rsp_type rsp_data;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // Model of the controller: registers and state
   logic [2:0]  cfg_pulses;
   logic [7:0]  cfg_window;
   logic        drive_on;
   logic        timeout_on;
   logic [3:0]  pulse_idx;
   logic [7:0]  peak_duty;
   logic [7:0]  hold_level;
   logic [7:0]  pulse_len;
   logic [7:0]  pulse_left;
   logic [11:0] run_left;
   logic [7:0]  spin_left;
   logic        return_begun;
   logic        remove_begun;
   logic [7:0]  duty_now;

   sphrc_req_type cmd_backlog[$];
   sphrc_rsp_type status_due[$];
   int            send_gap_pct;
   int            rsp_stall_pct;
   int            n_fail;
   int            n_queued;
   int            quiet_cycles;
   logic          req_fired;

   solenoid_peak_hold_release_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Drive model
   // -------------------------------------------------------------------------
   function automatic void clear_drive_model();
      cfg_pulses   = PULSE_COUNT_RST;
      cfg_window   = SPIN_WINDOW_RST;
      drive_on     = 1'b0;
      timeout_on   = 1'b1;
      pulse_idx    = PHASE_RST;
      peak_duty    = DUTY_OFF;
      hold_level   = DUTY_OFF;
      pulse_len    = '0;
      pulse_left   = '0;
      run_left     = '0;
      spin_left    = '0;
      return_begun = 1'b0;
      remove_begun = 1'b0;
      duty_now     = DUTY_OFF;
   endfunction

   // percentage saturates at 100 before scaling to 8 bits
   function automatic logic [7:0] pct_duty(input logic [6:0] pct);
      int p;
      p = (pct > PCT_MAX) ? int'(PCT_MAX) : int'(pct);
      return 8'(p * 255 / 100);
   endfunction

   function automatic void drop_drive();
      pulse_left = '0;
      run_left   = '0;
      duty_now   = DUTY_OFF;
      drive_on   = 1'b0;
      timeout_on = 1'b1;
   endfunction

   // odd phases drive hold, even ones inrush, until the pulses are used up
   function automatic void next_pulse();
      if (pulse_idx < {cfg_pulses, 1'b0}) begin
         duty_now   = pulse_idx[0] ? hold_level : peak_duty;
         pulse_idx  = pulse_idx + 4'd1;
         pulse_left = pulse_len;
      end else begin
         duty_now = hold_level;
      end
   endfunction

   function automatic sphrc_rsp_type solenoid_status_after(input sphrc_req_type c);
      sphrc_rsp_type r;
      int            span_tmo;
      int            span_pulses;
      r.event_res       = EVT_NONE;
      r.id_read_request = 1'b0;
      case (c.command)
         CMD_TICK: begin
            if (pulse_left != 0) pulse_left = pulse_left - 8'd1;
            if (run_left != 0) run_left = run_left - 12'd1;
            if (spin_left != 0) spin_left = spin_left - 8'd1;
            if (drive_on) begin
               if (run_left == 0 && timeout_on) begin
                  drop_drive();
                  r.event_res = EVT_TIMEOUT;
               end else if (pulse_left == 0) begin
                  next_pulse();
               end
            end else begin
               drop_drive();
            end
         end
         CMD_START: begin
            if (c.timeout_sec != TIMEOUT_OFF) begin
               span_tmo    = int'(c.timeout_sec) * 10;
               span_pulses = int'(c.inrush_period) * 2 * int'(cfg_pulses);
               pulse_len   = c.inrush_period;
               pulse_left  = c.inrush_period;
               peak_duty   = pct_duty(c.inrush_pct);
               duty_now    = peak_duty;
               pulse_idx   = PHASE_START;
               drive_on    = 1'b1;
               run_left    = 12'((span_tmo > span_pulses) ? span_tmo : span_pulses);
               timeout_on  = (c.timeout_sec != TIMEOUT_NONE);
               hold_level  = pct_duty(c.hold_pct);
            end else begin
               drop_drive();
            end
         end
         CMD_SENSOR: begin
            // spin window over: forget any spin in progress
            if (spin_left == 0) begin
               return_begun = 1'b0;
               remove_begun = 1'b0;
            end
            if (return_begun) begin
               if (c.sensor_a) begin
                  r.event_res = EVT_RETURNED;
                  spin_left   = '0;
               end
            end else if (remove_begun) begin
               if (c.sensor_a && c.sensor_b) begin
                  r.id_read_request = 1'b1;
                  r.event_res       = EVT_RELEASED;
                  spin_left         = '0;
                  drop_drive();
               end
            end else if (!c.sensor_a) begin
               spin_left = cfg_window;
               if (!c.sensor_b) begin
                  remove_begun = 1'b1;
               end else begin
                  r.id_read_request = 1'b1;
                  return_begun      = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.duty   = duty_now;
      r.active = drive_on;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Command builders
   // -------------------------------------------------------------------------
   // unused fields carry random bits on every command
   function automatic sphrc_req_type noise_item();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(sphrc_req_type)-1:0];
   endfunction

   function automatic void push_cmd(input sphrc_req_type it);
      cmd_backlog.push_back(it);
      if (it.command != CMD_UNUSED) n_queued++;
   endfunction

   function automatic void push_tick(input int n);
      sphrc_req_type it;
      repeat (n) begin
         it = noise_item();
         it.command = CMD_TICK;
         push_cmd(it);
      end
   endfunction

   function automatic void push_sensor(input logic a, input logic b);
      sphrc_req_type it;
      it = noise_item();
      it.command  = CMD_SENSOR;
      it.sensor_a = a;
      it.sensor_b = b;
      push_cmd(it);
   endfunction

   function automatic void push_start(input logic [6:0] pct_in, input logic [7:0] period,
                                      input logic [6:0] pct_hold, input logic [7:0] tmo);
      sphrc_req_type it;
      it = noise_item();
      it.command       = CMD_START;
      it.inrush_pct    = pct_in;
      it.inrush_period = period;
      it.hold_pct      = pct_hold;
      it.timeout_sec   = tmo;
      push_cmd(it);
   endfunction

   function automatic logic [6:0] rand_pct();
      if ($urandom_range(99) < 15) return 7'($urandom_range(127, 101));
      return 7'($urandom_range(100));
   endfunction

   function automatic logic [7:0] rand_tmo();
      int k;
      k = $urandom_range(99);
      if (k < 10) return TIMEOUT_OFF;
      if (k < 25) return TIMEOUT_NONE;
      if (k < 35) return 8'($urandom_range(255));
      return 8'($urandom_range(3, 1));
   endfunction

   function automatic logic [7:0] rand_period();
      if ($urandom_range(19) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(3));
   endfunction

   function automatic int rand_spin_ticks();
      if ($urandom_range(9) == 0) return $urandom_range(12);
      return $urandom_range(3);
   endfunction

   // one random scenario: drive run, remove spin, return spin, idle ticks or noise
   function automatic void queue_random_sequence();
      int kind;
      int n;
      kind = $urandom_range(99);
      if (kind < 30) begin
         push_start(rand_pct(), rand_period(), rand_pct(), rand_tmo());
         n = $urandom_range(40, 1);
         repeat (n) begin
            if ($urandom_range(9) == 0) push_sensor(1'($urandom), 1'($urandom));
            else push_tick(1);
         end
      end else if (kind < 55) begin
         if ($urandom_range(9) < 7) push_start(rand_pct(), rand_period(), rand_pct(), rand_tmo());
         push_sensor(1'b0, 1'b0);
         push_tick(rand_spin_ticks());
         if ($urandom_range(4) == 0) push_sensor(1'($urandom), 1'($urandom));
         if ($urandom_range(4) != 0) push_sensor(1'b1, 1'b1);
         else push_sensor(1'($urandom), 1'($urandom));
      end else if (kind < 75) begin
         push_sensor(1'b0, 1'b1);
         push_tick(rand_spin_ticks());
         if ($urandom_range(4) != 0) push_sensor(1'b1, 1'($urandom));
         else push_sensor(1'b0, 1'($urandom));
      end else if (kind < 85) begin
         push_tick($urandom_range(60, 20));
      end else begin
         repeat ($urandom_range(5, 1)) push_cmd(noise_item());
      end
   endfunction

   // -------------------------------------------------------------------------
   // Register port and synchronisation
   // -------------------------------------------------------------------------
   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_PULSE_COUNT) cfg_pulses = value[2:0];
      else cfg_window = value[7:0];
   endtask

   // nothing queued, nothing on the request side, no status outstanding
   task automatic wait_idle();
      @(posedge clock);
      while (cmd_backlog.size() != 0 || req_valid || status_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         n_fail++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Request driver and receiver back-pressure
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fired) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_data  <= cmd_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks results, models accepted commands, runs the watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      sphrc_rsp_type want;
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $error("status transaction with none outstanding: %h", rsp_data);
               n_fail++;
            end else begin
               want = status_due.pop_front();
               check_field("duty", want.duty, rsp_data.duty);
               check_field("active", want.active, rsp_data.active);
               check_field("event_res", want.event_res, rsp_data.event_res);
               check_field("id_read_request", want.id_read_request,
                           rsp_data.id_read_request);
            end
         end
         if (req_valid && req_ready) begin
            req_fired = 1'b1;
            status_due.push_back(solenoid_status_after(req_data));
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_solenoid_peak_hold_release_controller failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      sphrc_req_type it;
      int            pulse_plan[SEGMENTS];
      int            window_plan[SEGMENTS];
      int            seg;
      pulse_plan  = '{7, 1, 0, 3, -1, -1, 5, -1};
      window_plan = '{255, 1, 0, 10, -1, -1, 2, -1};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      n_fail        = 0;
      quiet_cycles  = 0;
      req_fired     = 1'b0;
      clear_drive_model();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // idle controller, then an undefined command
      push_tick(1);
      it = noise_item();
      it.command = CMD_UNUSED;
      push_cmd(it);
      // over-range inrush percentage, zero pulse length: pulsing on every tick
      push_start(7'd127, 8'd0, 7'd0, 8'd1);
      push_tick(3);
      // zero timeout stops the drive
      push_start(7'd100, 8'd255, 7'd100, TIMEOUT_OFF);
      // full duty with the timeout event disabled, settles at hold
      push_start(7'd100, 8'd1, 7'd127, TIMEOUT_NONE);
      push_tick(7);
      // remove spin releases and requests an ID read
      push_sensor(1'b0, 1'b0);
      push_sensor(1'b1, 1'b1);
      // return spin
      push_sensor(1'b0, 1'b1);
      push_sensor(1'b1, 1'b0);
      // both sensors high with no spin begun
      push_sensor(1'b1, 1'b1);
      // zero duties, longest pulse
      push_start(7'd0, 8'd255, 7'd0, 8'd254);
      push_tick(2);
      wait_idle();

      // random scenarios under each register setting and back-pressure mode
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 88; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 88; end
            default: begin send_gap_pct = 26; rsp_stall_pct = 26; end
         endcase
         csr_write(REG_PULSE_COUNT, (pulse_plan[seg] < 0) ?
                   32'($urandom_range(7)) : 32'(pulse_plan[seg]));
         csr_write(REG_SPIN_WINDOW, (window_plan[seg] < 0) ?
                   32'($urandom_range(255)) : 32'(window_plan[seg]));
         n_queued = 0;
         while (n_queued < RANDOM_ITEMS / SEGMENTS) queue_random_sequence();
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (status_due.size() != 0) begin
         $error("%0d status transactions never arrived", status_due.size());
         n_fail++;
      end
      if (n_fail == 0) begin
         $display("tb_solenoid_peak_hold_release_controller passed");
      end else begin
         $display("tb_solenoid_peak_hold_release_controller failed");
      end
      $finish;
   end

endmodule
